[rtl/tcprx_pkg.sv]
`timescale 1ns / 1ps

package tcprx_pkg;

    // verdict codes
    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
    localparam logic [1:0] VERDICT_BAD_FLAGS = 2'd2;
    localparam logic [1:0] VERDICT_CHECKSUM  = 2'd3;

    localparam logic [15:0] MIN_HEADER = 16'd20;
    localparam logic [15:0] PROTO_TCP  = 16'd6;

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_RST = 8'h04;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
        logic [7:0]  flag_bits;
    } out_item_t;

endpackage

[rtl/tcprx_ifs.sv]
`timescale 1ns / 1ps

interface tcprx_in_if;
    logic                valid;
    logic                ready;
    tcprx_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcprx_out_if;
    logic                 valid;
    logic                 ready;
    tcprx_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/tcp_segment_rx_checker.sv]
`timescale 1ns / 1ps

// a last-byte beat passes the input register and then the verdict register
// throughput: one segment byte per cycle while the input register is not stalled;
// the input register stalls only while a verdict waits in the output register and
// another last byte needs the output
// reset clears the running sum, byte count, caught header fields and both valid flags
module tcp_segment_rx_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tcprx_in_if.sink    segment,
    tcprx_out_if.source result
);
    import tcprx_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    // fold an 18-bit sum of 16-bit words back into a ones' complement word
    function automatic logic [15:0] ones_fold(input logic [17:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

    // zero flags, or syn with fin or rst
    function automatic logic flags_bogus(input logic [7:0] f);
        logic bogus;
        bogus = (f == 8'h00) ||
                (((f & FLAG_SYN) != 8'h00) && ((f & (FLAG_FIN | FLAG_RST)) != 8'h00));
        return bogus;
    endfunction

    // ---------------------------------------------------------------
    // input register: byte beat plus the pre-folded address words
    // ---------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic [7:0]  s1_byte_reg;
    logic [15:0] s1_addr_sum_reg;
    logic [15:0] addr_sum_next;
    logic        s1_go;
    logic        in_take;

    // source and destination address words folded first, then the protocol,
    // so no partial sum outgrows 18 bits
    assign addr_sum_next = ones_fold(
        {2'b00, ones_fold({2'b00, segment.data.source_address[31:16]}
                          + {2'b00, segment.data.source_address[15:0]}
                          + {2'b00, segment.data.destination_address[31:16]}
                          + {2'b00, segment.data.destination_address[15:0]})}
        + {2'b00, PROTO_TCP});

    logic out_valid_reg;

    // a non-final byte never needs the output; a final byte needs a free slot
    assign s1_go          = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign segment.ready  = !s1_valid_reg || s1_go;
    assign in_take        = segment.valid && segment.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (segment.ready)
        begin
            s1_valid_reg <= segment.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_first_reg    <= segment.data.first_byte;
            s1_last_reg     <= segment.data.last_byte;
            s1_byte_reg     <= segment.data.data_byte;
            s1_addr_sum_reg <= addr_sum_next;
        end
    end

    // ---------------------------------------------------------------
    // segment state
    // ---------------------------------------------------------------
    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_next;
    logic                   length_overflow_reg, length_overflow_next;
    logic [15:0]            ones_sum_reg, ones_sum_next;
    logic [7:0]             pending_high_byte_reg, pending_high_byte_next;
    logic [15:0]            src_port_reg, src_port_next;
    logic [15:0]            dst_port_reg, dst_port_next;
    logic [3:0]             offset_reg, offset_next;
    logic [7:0]             flags_reg, flags_next;

    // state as seen by this byte: a first byte starts from a clean slate
    logic [LENGTH_BITS-1:0] cnt_eff;
    logic                   ovf_eff;
    logic [15:0]            sum_eff;
    logic [7:0]             pend_eff;
    logic [15:0]            sp_eff, dp_eff;
    logic [3:0]             off_eff;
    logic [7:0]             flg_eff;

    // state after this byte is taken
    logic [LENGTH_BITS-1:0] cnt_upd;
    logic                   ovf_upd;
    logic [15:0]            sum_upd;
    logic [7:0]             pend_upd;
    logic [15:0]            sp_upd, dp_upd;
    logic [3:0]             off_upd;
    logic [7:0]             flg_upd;

    logic        at_max;
    logic [15:0] word_add;
    logic [15:0] seg_len;
    logic [15:0] hdr_len;
    logic [15:0] total_sum;
    logic [1:0]  verdict;
    out_item_t   out_data_next;
    out_item_t   out_data_reg;

    always_comb
    begin
        cnt_eff  = s1_first_reg ? '0    : byte_count_reg;
        ovf_eff  = s1_first_reg ? 1'b0  : length_overflow_reg;
        sum_eff  = s1_first_reg ? 16'd0 : ones_sum_reg;
        pend_eff = s1_first_reg ? 8'd0  : pending_high_byte_reg;
        sp_eff   = s1_first_reg ? 16'd0 : src_port_reg;
        dp_eff   = s1_first_reg ? 16'd0 : dst_port_reg;
        off_eff  = s1_first_reg ? 4'd0  : offset_reg;
        flg_eff  = s1_first_reg ? 8'd0  : flags_reg;

        at_max = (cnt_eff == CNT_MAX);

        // odd position completes a word, even position opens one (zero padded)
        word_add = cnt_eff[0] ? {pend_eff, s1_byte_reg} : {s1_byte_reg, 8'h00};

        cnt_upd  = cnt_eff;
        ovf_upd  = ovf_eff;
        sum_upd  = sum_eff;
        pend_upd = pend_eff;
        sp_upd   = sp_eff;
        dp_upd   = dp_eff;
        off_upd  = off_eff;
        flg_upd  = flg_eff;

        if (at_max)
        begin
            // saturate; the byte is dropped
            ovf_upd = 1'b1;
        end
        else
        begin
            if (cnt_eff[0])
            begin
                sum_upd = ones_fold({2'b00, sum_eff} + {2'b00, word_add});
            end
            else
            begin
                pend_upd = s1_byte_reg;
            end
            if (cnt_eff == LENGTH_BITS'(0))  sp_upd[15:8] = s1_byte_reg;
            if (cnt_eff == LENGTH_BITS'(1))  sp_upd[7:0]  = s1_byte_reg;
            if (cnt_eff == LENGTH_BITS'(2))  dp_upd[15:8] = s1_byte_reg;
            if (cnt_eff == LENGTH_BITS'(3))  dp_upd[7:0]  = s1_byte_reg;
            if (cnt_eff == LENGTH_BITS'(12)) off_upd      = s1_byte_reg[7:4];
            if (cnt_eff == LENGTH_BITS'(13)) flg_upd      = s1_byte_reg;
            cnt_upd = cnt_eff + LENGTH_BITS'(1);
        end

        seg_len = 16'(cnt_upd);
        hdr_len = {10'd0, off_upd, 2'b00};

        // segment words, the padded tail, address words and length in one add;
        // only meaningful when no overflow, which the verdict checks first
        total_sum = ones_fold({2'b00, sum_eff} + {2'b00, word_add}
                              + {2'b00, s1_addr_sum_reg} + {2'b00, seg_len});

        if (ovf_upd || seg_len < MIN_HEADER)
        begin
            verdict = VERDICT_MALFORMED;
        end
        else if (hdr_len < MIN_HEADER || hdr_len > seg_len)
        begin
            verdict = VERDICT_MALFORMED;
        end
        else if (flags_bogus(flg_upd))
        begin
            verdict = VERDICT_BAD_FLAGS;
        end
        else if (total_sum != 16'hFFFF)
        begin
            verdict = VERDICT_CHECKSUM;
        end
        else
        begin
            verdict = VERDICT_OK;
        end

        out_data_next.verdict          = verdict;
        out_data_next.source_port      = sp_upd;
        out_data_next.destination_port = dp_upd;
        out_data_next.header_bytes     = hdr_len[5:0];
        out_data_next.payload_bytes    = (verdict == VERDICT_OK) ? (seg_len - hdr_len) : 16'd0;
        out_data_next.flag_bits        = flg_upd;

        // a last byte closes the segment and clears everything
        if (s1_last_reg)
        begin
            byte_count_next        = '0;
            length_overflow_next   = 1'b0;
            ones_sum_next          = 16'd0;
            pending_high_byte_next = 8'd0;
            src_port_next          = 16'd0;
            dst_port_next          = 16'd0;
            offset_next            = 4'd0;
            flags_next             = 8'd0;
        end
        else
        begin
            byte_count_next        = cnt_upd;
            length_overflow_next   = ovf_upd;
            ones_sum_next          = sum_upd;
            pending_high_byte_next = pend_upd;
            src_port_next          = sp_upd;
            dst_port_next          = dp_upd;
            offset_next            = off_upd;
            flags_next             = flg_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg        <= '0;
            length_overflow_reg   <= 1'b0;
            ones_sum_reg          <= 16'd0;
            pending_high_byte_reg <= 8'd0;
            src_port_reg          <= 16'd0;
            dst_port_reg          <= 16'd0;
            offset_reg            <= 4'd0;
            flags_reg             <= 8'd0;
        end
        else if (s1_go)
        begin
            byte_count_reg        <= byte_count_next;
            length_overflow_reg   <= length_overflow_next;
            ones_sum_reg          <= ones_sum_next;
            pending_high_byte_reg <= pending_high_byte_next;
            src_port_reg          <= src_port_next;
            dst_port_reg          <= dst_port_next;
            offset_reg            <= offset_next;
            flags_reg             <= flags_next;
        end
    end

    // ---------------------------------------------------------------
    // verdict register
    // ---------------------------------------------------------------
    logic out_valid_next;
    logic out_load;

    assign out_load = s1_go && s1_last_reg;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // a verdict beat only appears after a last byte left the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("verdict beat without a last byte");

    // closing a segment leaves the count and overflow flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (byte_count_reg == '0 && !length_overflow_reg))
        else $error("segment state not cleared after last byte");

    // overflow only ever sits with a saturated count
    assert property (@(posedge clk) disable iff (!rst_n)
        length_overflow_reg |-> (byte_count_reg == CNT_MAX))
        else $error("overflow flag with unsaturated count");

    // an accepted segment always has a legal header length
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.verdict == VERDICT_OK)
            |-> ({10'd0, result.data.header_bytes} >= MIN_HEADER))
        else $error("ok verdict with short header");

endmodule

[bench/tb_tcp_segment_rx_checker.sv]
`timescale 1ns / 1ps

module tb_tcp_segment_rx_checker;
    import tcprx_pkg::*;

    localparam int SEG_LEN_BITS  = 16;
    localparam int SEG_MAX_COUNT = (1 << SEG_LEN_BITS) - 1;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;

    // flag bits the package does not name
    localparam logic [7:0] FLAG_PSH = 8'h08;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    // one row of the directed segment list
    typedef struct {
        int          len;
        logic [3:0]  nib;
        logic [7:0]  flags;
        bit          fix_sum;
        bit          flip_sum;
        int          lead;
        bit          no_first;
        logic [31:0] src;
        logic [31:0] dst;
        bit          typed;
        logic [1:0]  verdict;
    } seg_case_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcprx_in_if  segment_ch ();
    tcprx_out_if result_ch ();

    tcp_segment_rx_checker #(
        .LENGTH_BITS(SEG_LEN_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .segment(segment_ch),
        .result (result_ch)
    );

    // running image of the checker, advanced on every accepted byte beat
    int          seg_bytes_seen = 0;
    bit          seg_overflow   = 1'b0;
    logic [15:0] seg_sum        = '0;
    logic [7:0]  seg_high       = '0;
    logic [15:0] seg_sport      = '0;
    logic [15:0] seg_dport      = '0;
    logic [3:0]  seg_nibble     = '0;
    logic [7:0]  seg_flags      = '0;

    // verdicts still owed by the block, oldest first
    out_item_t   verdict_queue [$];
    // bytes of the segment about to be sent
    logic [7:0]  segment_bytes [$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic result_hold    = 1'b0;
    int   beats_sent     = 0;
    int   verdicts_seen  = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    seg_case_t  dir_cases [22];
    logic [7:0] good_flags [7];

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // 16-bit add with end-around carry
    function automatic logic [15:0] ones_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    task automatic clear_segment_state();
        seg_bytes_seen = 0;
        seg_overflow   = 1'b0;
        seg_sum        = '0;
        seg_high       = '0;
        seg_sport      = '0;
        seg_dport      = '0;
        seg_nibble     = '0;
        seg_flags      = '0;
    endtask

    // advance the checker image by one byte; a last byte yields one verdict
    task automatic track_segment_byte(input in_item_t beat);
        logic [15:0] seg_len;
        logic [5:0]  hdr;
        logic [15:0] total;
        logic [1:0]  v;
        bit          bogus;
        out_item_t   want;
        if (beat.first_byte)
            clear_segment_state();
        if (seg_bytes_seen >= SEG_MAX_COUNT)
            seg_overflow = 1'b1;  // count saturates, byte neither summed nor caught
        else
        begin
            // even positions wait for their low byte partner
            if (seg_bytes_seen[0] == 1'b0)
                seg_high = beat.data_byte;
            else
                seg_sum = ones_fold(seg_sum, {seg_high, beat.data_byte});
            case (seg_bytes_seen)
                0:  seg_sport[15:8] = beat.data_byte;
                1:  seg_sport[7:0]  = beat.data_byte;
                2:  seg_dport[15:8] = beat.data_byte;
                3:  seg_dport[7:0]  = beat.data_byte;
                12: seg_nibble      = beat.data_byte[7:4];
                13: seg_flags       = beat.data_byte;
                default: ;
            endcase
            seg_bytes_seen = seg_bytes_seen + 1;
        end
        if (beat.last_byte)
        begin
            seg_len = seg_bytes_seen[15:0];
            hdr     = {seg_nibble, 2'b00};
            // odd tail padded with a zero low byte, then the pseudo header
            total   = seg_sum;
            if (seg_bytes_seen[0])
                total = ones_fold(total, {seg_high, 8'h00});
            total = ones_fold(total, beat.source_address[31:16]);
            total = ones_fold(total, beat.source_address[15:0]);
            total = ones_fold(total, beat.destination_address[31:16]);
            total = ones_fold(total, beat.destination_address[15:0]);
            total = ones_fold(total, PROTO_TCP);
            total = ones_fold(total, seg_len);
            // zero flags, or syn together with fin or rst
            bogus = (seg_flags == 8'h00) ||
                    (((seg_flags & FLAG_SYN) != 8'h00) &&
                     ((seg_flags & (FLAG_FIN | FLAG_RST)) != 8'h00));
            if (seg_overflow || seg_len < MIN_HEADER)
                v = VERDICT_MALFORMED;
            else if ({10'd0, hdr} < MIN_HEADER || {10'd0, hdr} > seg_len)
                v = VERDICT_MALFORMED;
            else if (bogus)
                v = VERDICT_BAD_FLAGS;
            else if (~total != 16'h0000)
                v = VERDICT_CHECKSUM;
            else
                v = VERDICT_OK;
            want.verdict          = v;
            want.source_port      = seg_sport;
            want.destination_port = seg_dport;
            want.header_bytes     = hdr;
            want.payload_bytes    = (v == VERDICT_OK) ? seg_len - {10'd0, hdr} : 16'd0;
            want.flag_bits        = seg_flags;
            verdict_queue.push_back(want);
            clear_segment_state();
        end
    endtask

    // random segment body with the offset nibble and flags placed, and,
    // when asked, a checksum that balances the pseudo header
    task automatic build_segment(input int len, input logic [3:0] nib, input logic [7:0] flags,
                                 input bit fix_sum, input bit flip_sum,
                                 input logic [31:0] src, input logic [31:0] dst);
        logic [15:0] acc;
        logic [7:0]  lo;
        logic [7:0]  b12;
        segment_bytes.delete();
        for (int i = 0; i < len; i++)
            segment_bytes.push_back(8'($urandom));
        if (len > 12)
        begin
            b12 = segment_bytes[12];
            segment_bytes[12] = {nib, b12[3:0]};
        end
        if (len > 13)
            segment_bytes[13] = flags;
        if (fix_sum && len >= 18 && len <= SEG_MAX_COUNT)
        begin
            segment_bytes[16] = 8'h00;
            segment_bytes[17] = 8'h00;
            acc = '0;
            for (int i = 0; i < len; i += 2)
            begin
                lo  = (i + 1 < len) ? segment_bytes[i + 1] : 8'h00;
                acc = ones_fold(acc, {segment_bytes[i], lo});
            end
            acc = ones_fold(acc, src[31:16]);
            acc = ones_fold(acc, src[15:0]);
            acc = ones_fold(acc, dst[31:16]);
            acc = ones_fold(acc, dst[15:0]);
            acc = ones_fold(acc, PROTO_TCP);
            acc = ones_fold(acc, 16'(len));
            acc = ~acc;
            segment_bytes[16] = acc[15:8];
            // a single flipped bit can never land on the other zero
            segment_bytes[17] = flip_sum ? (acc[7:0] ^ 8'h01) : acc[7:0];
        end
    endtask

    // offer one byte beat, idling first at random, and wait for the handshake
    task automatic send_beat(input in_item_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            segment_ch.valid <= 1'b0;
            @(posedge clk);
        end
        segment_ch.valid <= 1'b1;
        segment_ch.data  <= beat;
        do
            @(posedge clk);
        while (!segment_ch.ready);
        track_segment_byte(beat);
        beats_sent = beats_sent + 1;
    endtask

    // addresses only matter on the last byte, the rest carry noise
    task automatic send_segment(input bit mark_first, input bit close,
                                input logic [31:0] src, input logic [31:0] dst);
        in_item_t beat;
        for (int i = 0; i < segment_bytes.size(); i++)
        begin
            beat.data_byte  = segment_bytes[i];
            beat.first_byte = mark_first && (i == 0);
            beat.last_byte  = close && (i == segment_bytes.size() - 1);
            beat.source_address      = beat.last_byte ? src : $urandom;
            beat.destination_address = beat.last_byte ? dst : $urandom;
            send_beat(beat);
        end
    endtask

    // replace the verdict of the newest expectation by a hand-written one
    task automatic pin_verdict(input logic [1:0] v);
        out_item_t want;
        want = verdict_queue.pop_back();
        want.verdict = v;
        if (v != VERDICT_OK)
            want.payload_bytes = '0;
        verdict_queue.push_back(want);
    endtask

    // mostly well-formed segments, plus short ones and loose marker noise
    task automatic random_segment();
        int          pick;
        int          len;
        int          payload;
        logic [3:0]  nib;
        logic [7:0]  flags;
        bit          mark_first;
        logic [31:0] src;
        logic [31:0] dst;
        in_item_t    beat;
        pick = $urandom_range(99);
        src  = $urandom;
        dst  = $urandom;
        // never continue a segment left open by noise
        mark_first = (seg_bytes_seen != 0) || ($urandom_range(9) != 0);
        if (pick < 65)
        begin
            nib     = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom_range(15));
            payload = ($urandom_range(99) < 2) ? $urandom_range(100, 600)
                                               : $urandom_range(0, 16);
            len     = ((nib < 5) ? 20 : nib * 4) + payload;
            flags   = ($urandom_range(99) < 70) ? good_flags[$urandom_range(6)]
                                                : 8'($urandom);
            build_segment(len, nib, flags, 1'b1, $urandom_range(99) < 10, src, dst);
            send_segment(mark_first, 1'b1, src, dst);
        end
        else if (pick < 85)
        begin
            build_segment($urandom_range(1, 19), 4'($urandom), 8'($urandom),
                          1'b0, 1'b0, src, dst);
            send_segment(mark_first, 1'b1, src, dst);
        end
        else
        begin
            repeat ($urandom_range(1, 40))
            begin
                beat.data_byte           = 8'($urandom);
                beat.first_byte          = ($urandom_range(11) == 0);
                beat.last_byte           = ($urandom_range(11) == 0);
                beat.source_address      = $urandom;
                beat.destination_address = $urandom;
                send_beat(beat);
            end
        end
    endtask

    // verdict beat checker and receiver ready
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        out_item_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            verdicts_seen = verdicts_seen + 1;
            if (verdict_queue.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("verdict beat %0d with nothing pending: %p", verdicts_seen, got);
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (got.verdict !== want.verdict ||
                    got.source_port !== want.source_port ||
                    got.destination_port !== want.destination_port ||
                    got.header_bytes !== want.header_bytes ||
                    got.payload_bytes !== want.payload_bytes ||
                    got.flag_bits !== want.flag_bits)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("verdict beat %0d: expected %p, got %p",
                                 verdicts_seen, want, got);
                end
            end
        end
        result_ch.ready <= !result_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        int        phase_idle [4];
        int        phase_stall [4];
        int        phase_start;
        seg_case_t row;
        logic [31:0] src;
        logic [31:0] dst;

        segment_ch.valid = 1'b0;
        segment_ch.data  = '0;

        good_flags = '{FLAG_ACK, FLAG_ACK | FLAG_PSH, FLAG_SYN, FLAG_SYN | FLAG_ACK,
                       FLAG_FIN | FLAG_ACK, FLAG_RST | FLAG_ACK, FLAG_RST};

        // len, nibble, flags, fix sum, flip sum, lead bytes, no first marker,
        // source, destination, verdict written by hand, that verdict
        dir_cases = '{
            // lone byte carrying both markers
            '{1, 4'd0, 8'h00, 1'b0, 1'b0, 0, 1'b0, 32'h0, 32'h0, 1'b1, VERDICT_MALFORMED},
            // one byte short of a minimal header
            '{19, 4'd5, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            // minimal segments, addresses at both extremes
            '{20, 4'd5, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'h0, 32'h0, 1'b1, VERDICT_OK},
            '{20, 4'd5, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF,
              1'b1, VERDICT_OK},
            // largest header
            '{60, 4'd15, FLAG_ACK | FLAG_PSH, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_OK},
            // odd length, tail byte padded
            '{21, 4'd5, FLAG_FIN | FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'h12345678, 32'h9ABCDEF0,
              1'b0, VERDICT_OK},
            // header length under twenty
            '{20, 4'd4, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            '{20, 4'd0, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            // header longer than the segment
            '{20, 4'd6, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            // header exactly as long as the segment, empty payload
            '{40, 4'd10, FLAG_ACK, 1'b1, 1'b0, 0, 1'b0, 32'hAC100005, 32'hAC100006,
              1'b0, VERDICT_OK},
            // bogus flag combinations
            '{20, 4'd5, 8'h00, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_BAD_FLAGS},
            '{20, 4'd5, FLAG_SYN | FLAG_FIN, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_BAD_FLAGS},
            '{20, 4'd5, FLAG_SYN | FLAG_RST, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_BAD_FLAGS},
            '{20, 4'd5, 8'hFF, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_BAD_FLAGS},
            // syn alone and rst alone pass
            '{20, 4'd5, FLAG_SYN, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_OK},
            '{20, 4'd5, FLAG_RST, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_OK},
            // one checksum bit wrong
            '{24, 4'd5, FLAG_ACK, 1'b1, 1'b1, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_CHECKSUM},
            // first marker cuts off an unfinished segment
            '{30, 4'd5, FLAG_ACK, 1'b1, 1'b0, 7, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_OK},
            // new segment after a last byte, no first marker
            '{26, 4'd6, FLAG_ACK, 1'b1, 1'b0, 0, 1'b1, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_OK},
            // very short, no flags byte reached
            '{5, 4'd0, 8'h00, 1'b0, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            // malformed header outranks bogus flags
            '{20, 4'd4, 8'h00, 1'b1, 1'b0, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_MALFORMED},
            // bogus flags outrank a bad checksum
            '{20, 4'd5, FLAG_SYN | FLAG_FIN, 1'b1, 1'b1, 0, 1'b0, 32'hC0A80001, 32'h0A000002,
              1'b1, VERDICT_BAD_FLAGS}
        };

        phase_idle  = '{0, 64, 0, 10};
        phase_stall = '{0, 0, 64, 10};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed segments, no idling
        foreach (dir_cases[k])
        begin
            row = dir_cases[k];
            if (row.lead > 0)
            begin
                build_segment(row.lead, 4'd5, FLAG_ACK, 1'b0, 1'b0, row.src, row.dst);
                send_segment(1'b1, 1'b0, row.src, row.dst);
            end
            build_segment(row.len, row.nib, row.flags, row.fix_sum, row.flip_sum,
                          row.src, row.dst);
            send_segment(!row.no_first, 1'b1, row.src, row.dst);
            if (row.typed)
                pin_verdict(row.verdict);
        end

        // receiver holds off while single-byte segments keep coming, so the
        // output register fills and the input stalls
        fork
            begin
                result_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_hold <= 1'b0;
            end
        join_none
        repeat (30)
        begin
            src = $urandom;
            dst = $urandom;
            build_segment(1, 4'd0, 8'h00, 1'b0, 1'b0, src, dst);
            send_segment(1'b1, 1'b1, src, dst);
        end
        repeat (4)
        begin
            src = $urandom;
            dst = $urandom;
            build_segment(20, 4'd5, FLAG_ACK, 1'b1, 1'b0, src, dst);
            send_segment(1'b1, 1'b1, src, dst);
        end

        // random segments under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            phase_start    = beats_sent;
            while (beats_sent - phase_start < 250)
                random_segment();
        end

        segment_ch.valid <= 1'b0;

        // drain, then wait on for any stray verdict beat
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
